// File: rtl/core/jhps_pkg.sv
// Package for the Jacobi heat plate solver: shared constants, types and helpers.
// No dependencies.
package jhps_pkg;

    localparam int MAX_SIDE_DEF = 128;
    localparam logic signed [31:0] PLATE_INIT = 32'sd655360;
    localparam logic [7:0]  GRID_SIZE_RST  = 8'd128;
    localparam logic [15:0] ITER_COUNT_RST = 16'd100;
    localparam logic [2:0]  ADDR_GRID_SIZE = 3'd0;
    localparam logic [2:0]  ADDR_ITER_COUNT = 3'd4;
    localparam logic [16:0] RECIP_TENTH = 17'd6554;

    typedef struct packed {
        logic [7:0]  grid_size;
        logic [15:0] iteration_count;
    } cfg_t;

    // floor(x / 10) for x below 8192 by reciprocal multiply
    function automatic logic [15:0] div10(input logic [15:0] x);
        logic [32:0] prod;
        begin
            prod = {17'd0, x} * {16'd0, RECIP_TENTH};
            return prod[31:16];
        end
    endfunction

endpackage

// File: rtl/core/jhps_ram.sv
// Single-write, single-read synchronous memory with registered read data.
// No dependencies.
module jhps_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/jhps_engine.sv
// Plate engine: builds the plate, runs the sweeps over two ping-pong memories.
// Depends on jhps_pkg and jhps_ram.
module jhps_engine #(
    parameter int MAX_SIDE = jhps_pkg::MAX_SIDE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  jhps_pkg::cfg_t     cfg,
    input  logic               start,
    input  logic [31:0]        rad,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [31:0]        res_data
);

    localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_FRD   = 3'd3;
    localparam logic [2:0] ST_FWAIT = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [IW-1:0] nm1_reg, nm1_next, nm2_reg, nm2_next;
    logic [IW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [15:0] iter_reg, iter_next, it_reg, it_next;
    logic [2:0]  ph_reg, ph_next;
    logic        odd_reg, odd_next;
    logic signed [33:0] acc_reg, acc_next;
    logic [31:0] rad_reg, rad_next;

    logic [AW-1:0] raddr, waddr;
    logic [31:0]   wdata, rd_even, rd_odd, rd;
    logic          we_even, we_odd;
    logic signed [33:0] sum;
    logic [31:0]   quarter, init_val;
    int            n_int;
    logic [15:0]   lo_calc, hi_calc;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(r) * AW'(MAX_SIDE) + AW'(c);
    endfunction

    jhps_ram #(.W(32), .DEPTH(DEPTH), .AW(AW)) u_even (
        .clk(clk), .we(we_even), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd_even)
    );

    jhps_ram #(.W(32), .DEPTH(DEPTH), .AW(AW)) u_odd (
        .clk(clk), .we(we_odd), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd_odd)
    );

    assign rd       = odd_reg ? rd_odd : rd_even;
    assign sum      = acc_reg + 34'(signed'(rd));
    assign quarter  = 32'(sum >>> 2);
    assign init_val = (i_reg == nm1_reg && j_reg >= lo_reg && j_reg <= hi_reg)
                      ? rad_reg : jhps_pkg::PLATE_INIT;
    assign waddr    = cell_addr(i_reg, j_reg);
    assign wdata    = (state_reg == ST_INIT) ? init_val : quarter;
    assign we_even  = (state_reg == ST_INIT) ||
                      (state_reg == ST_SWEEP && ph_reg == 3'd4 && odd_reg);
    assign we_odd   = (state_reg == ST_INIT) ||
                      (state_reg == ST_SWEEP && ph_reg == 3'd4 && !odd_reg);
    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FWAIT);
    assign res_data  = rd;

    // clamp side and work out radiator column bounds
    always_comb
    begin
        n_int = int'(cfg.grid_size);
        if (n_int < 3)
        begin
            n_int = 3;
        end
        if (n_int > MAX_SIDE)
        begin
            n_int = MAX_SIDE;
        end
        lo_calc = jhps_pkg::div10(16'(3 * (n_int - 1)));
        hi_calc = jhps_pkg::div10(16'(7 * (n_int - 1) + 9));
    end

    always_comb
    begin
        raddr = '0;
        case (state_reg)
            ST_SWEEP:
            begin
                case (ph_reg)
                    3'd0:    raddr = cell_addr(i_reg + 1'b1, j_reg);
                    3'd1:    raddr = cell_addr(i_reg - 1'b1, j_reg);
                    3'd2:    raddr = cell_addr(i_reg, j_reg + 1'b1);
                    3'd3:    raddr = cell_addr(i_reg, j_reg - 1'b1);
                    default: raddr = cell_addr(i_reg, j_reg);
                endcase
            end
            ST_FRD, ST_FWAIT: raddr = cell_addr(mid_reg, mid_reg);
            default: raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        nm1_next = nm1_reg;
        nm2_next = nm2_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        iter_next = iter_reg;
        it_next = it_reg;
        ph_next = ph_reg;
        odd_next = odd_reg;
        acc_next = acc_reg;
        rad_next = rad_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    nm1_next  = IW'(n_int - 1);
                    nm2_next  = IW'(n_int - 2);
                    mid_next  = IW'((n_int - 1) >> 1);
                    lo_next   = IW'(lo_calc);
                    hi_next   = IW'(hi_calc);
                    iter_next = cfg.iteration_count;
                    rad_next  = rad;
                    i_next    = '0;
                    j_next    = '0;
                    it_next   = '0;
                    odd_next  = 1'b0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (j_reg == nm1_reg)
                begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                    if (i_reg == nm1_reg)
                    begin
                        i_next = IW'(1);
                        j_next = IW'(1);
                        ph_next = '0;
                        state_next = (iter_reg == '0) ? ST_FRD : ST_SWEEP;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_SWEEP:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 3'd1)
                begin
                    acc_next = 34'(signed'(rd));
                end
                else if (ph_reg == 3'd2 || ph_reg == 3'd3)
                begin
                    acc_next = sum;
                end
                else if (ph_reg == 3'd4)
                begin
                    ph_next = '0;
                    if (j_reg == nm2_reg)
                    begin
                        j_next = IW'(1);
                        i_next = i_reg + 1'b1;
                        if (i_reg == nm2_reg)
                        begin
                            // plate done: swap buffers
                            i_next = IW'(1);
                            odd_next = !odd_reg;
                            it_next = it_reg + 1'b1;
                            if (it_reg + 1'b1 == iter_reg)
                            begin
                                state_next = ST_FRD;
                            end
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_FRD:
            begin
                state_next = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= '0;
            odd_reg   <= 1'b0;
            it_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            odd_reg   <= odd_next;
            it_reg    <= it_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nm1_reg  <= nm1_next;
        nm2_reg  <= nm2_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        iter_reg <= iter_next;
        acc_reg  <= acc_next;
        rad_reg  <= rad_next;
    end

endmodule

// File: rtl/core/jacobi_heat_plate_solver.sv
// Top level of the Jacobi heat plate solver: register port, stream ports, result register.
// Depends on jhps_pkg and jhps_engine.
//
//  channel | dir | payload
//  s_*     | in  | radiator_temp [31:0]
//  m_*     | out | center_temp [31:0]
//  apb     | in  | grid_size @0x0, iteration_count @0x4
//
// For each item the plate is written one cell a cycle, then each interior cell needs
// four reads on the single memory read port and one write. Reset is asynchronous;
// the memories need no clearing since every item rewrites the plate. The result
// waits in an output register; s_tready is high only while the engine is idle.
module jacobi_heat_plate_solver #(
    parameter int MAX_SIDE = jhps_pkg::MAX_SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] radiator_temp
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] center_temp
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    jhps_pkg::cfg_t cfg_reg, cfg_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic        idle, res_valid, res_ready;
    logic [31:0] res_data;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == jhps_pkg::ADDR_ITER_COUNT[2])
                     ? {16'd0, cfg_reg.iteration_count} : {24'd0, cfg_reg.grid_size};
    assign s_tready  = idle;
    assign res_ready = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    jhps_engine #(.MAX_SIDE(MAX_SIDE)) u_engine (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .start(s_tvalid && s_tready), .rad(s_tdata),
        .idle(idle), .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == jhps_pkg::ADDR_ITER_COUNT[2])
            begin
                cfg_next.iteration_count = pwdata[15:0];
            end
            else
            begin
                cfg_next.grid_size = pwdata[7:0];
            end
        end
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_size       <= jhps_pkg::GRID_SIZE_RST;
            cfg_reg.iteration_count <= jhps_pkg::ITER_COUNT_RST;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("engine took a second item");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_tready)
        else $error("result offered while idle");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> m_tvalid)
        else $error("result beat lost");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped under stall");

endmodule
